>>> sv/ppe_pkg.sv
`timescale 1ns / 1ps
package ppe_pkg;

  localparam int unsigned PoolSizeDef = 64;
  localparam int unsigned MaxRec      = 64;
  localparam int unsigned OneQ12      = 4096;

  // command codes
  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_EMIT = 1'b1
  } cmd_e;

  // register indexes
  localparam logic [2:0] REG_BASE_VEL   = 3'd0;
  localparam logic [2:0] REG_VEL_SPREAD = 3'd1;
  localparam logic [2:0] REG_BASE_COLOR = 3'd2;
  localparam logic [2:0] REG_LIFE_TIME  = 3'd3;
  localparam logic [2:0] REG_SIZE_BEGIN = 3'd4;
  localparam logic [2:0] REG_SIZE_END   = 3'd5;
  localparam logic [2:0] REG_SIZE_SPRD  = 3'd6;
  localparam logic [2:0] REG_FADE_STYLE = 3'd7;

  typedef struct packed {
    logic        cmd;
    logic [15:0] time_step;
    logic signed [23:0] emit_x;
    logic signed [23:0] emit_y;
    logic signed [7:0]  rand_vx;
    logic signed [7:0]  rand_vy;
    logic signed [7:0]  rand_size;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  slot;
    logic signed [23:0] offset_x;
    logic signed [23:0] offset_y;
    logic [23:0] color_rgb;
    logic [12:0] alpha;
    logic [15:0] draw_size;
    logic        none_active;
    logic        last;
  } out_item_t;

  // one particle as it travels along the chain of cells
  typedef struct packed {
    logic        active;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [16:0] vel_x;
    logic signed [16:0] vel_y;
    logic signed [16:0] life_left;
    logic [15:0] life_total;
    logic [15:0] start_size;
    logic [15:0] final_size;
    logic [23:0] color;
    logic        fade;
  } part_t;

  function automatic logic signed [23:0] sat24(input logic signed [25:0] v);
    logic signed [23:0] r;
    if (v > 26'sd8388607) r = 24'sh7FFFFF;
    else if (v < -26'sd8388608) r = 24'sh800000;
    else r = v[23:0];
    return r;
  endfunction

endpackage

>>> sv/ppe_if.sv
`timescale 1ns / 1ps
interface ppe_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> sv/particle_pool_engine.sv
`timescale 1ns / 1ps
// Particle pool engine.
// Input channel in_if carries an item of command, time_step, emitter position
// and three random values; output channel out_if carries render records.
// Configuration goes through an APB port, register i at byte address 4*i.
// An emit item first rotates the ring of POOL_SIZE cells until the slot for
// the next emit (taken round robin) sits at the head, then writes it in
// ST_EMIT_MUL and ST_EMIT_WR. A tick item rotates the ring until slot 0 is at
// the head, updates every slot in turn (ST_UPD_MUL, ST_UPD_WR), then rotates
// once more to report in slot order: each active particle goes through the
// serial life division, alpha and size, then the record. The serial divider
// and the single head read port set the pace of the report pass.
// One item is worked on at a time; in_if.ready is low until it is done.
// Records wait in an output register; while the receiver stalls the engine
// holds. A tick with no active particle gives one record with none_active.
// Reset clears all active marks, the ring pointer and the registers to
// their defaults; no clearing pass is needed.
module particle_pool_engine #(
  parameter int unsigned POOL_SIZE = ppe_pkg::PoolSizeDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ppe_if.sink         in_if,
  ppe_if.source       out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ppe_pkg::*;

  localparam int unsigned SlotW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int unsigned CntW  = $clog2(POOL_SIZE + 1);

  // configuration registers
  logic [31:0] base_vel_q, vel_spread_q;
  logic [23:0] base_color_q;
  logic [15:0] life_time_q, size_begin_q, size_end_q, size_spread_q;
  logic        fade_style_q;
  logic [2:0]  reg_idx;
  logic        wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_vel_q    <= '0;
      vel_spread_q  <= '0;
      base_color_q  <= 24'hFFFFFF;
      life_time_q   <= 16'd4096;
      size_begin_q  <= 16'd2560;
      size_end_q    <= '0;
      size_spread_q <= '0;
      fade_style_q  <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_BASE_VEL:   base_vel_q    <= pwdata;
        REG_VEL_SPREAD: vel_spread_q  <= pwdata;
        REG_BASE_COLOR: base_color_q  <= pwdata[23:0];
        REG_LIFE_TIME:  life_time_q   <= pwdata[15:0];
        REG_SIZE_BEGIN: size_begin_q  <= pwdata[15:0];
        REG_SIZE_END:   size_end_q    <= pwdata[15:0];
        REG_SIZE_SPRD:  size_spread_q <= pwdata[15:0];
        REG_FADE_STYLE: fade_style_q  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_BASE_VEL:   prdata = base_vel_q;
      REG_VEL_SPREAD: prdata = vel_spread_q;
      REG_BASE_COLOR: prdata = {8'd0, base_color_q};
      REG_LIFE_TIME:  prdata = {16'd0, life_time_q};
      REG_SIZE_BEGIN: prdata = {16'd0, size_begin_q};
      REG_SIZE_END:   prdata = {16'd0, size_end_q};
      REG_SIZE_SPRD:  prdata = {16'd0, size_spread_q};
      REG_FADE_STYLE: prdata = {31'd0, fade_style_q};
      default:        prdata = '0;
    endcase
  end

  // ring of cells; head is cell 0, the ring shifts toward it
  part_t ring_in  [POOL_SIZE];
  part_t ring_out [POOL_SIZE];
  part_t head_new;
  logic  shift;

  for (genvar g = 0; g < POOL_SIZE; g++) begin : g_cell
    ppe_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(shift),
      .part_i (ring_in[g]),
      .part_o (ring_out[g])
    );
    if (g == POOL_SIZE - 1) begin : g_tail
      assign ring_in[g] = head_new;
    end else begin : g_mid
      assign ring_in[g] = ring_out[g + 1];
    end
  end

  typedef enum logic [3:0] {
    ST_IDLE, ST_SEEK, ST_EMIT_MUL, ST_EMIT_WR,
    ST_UPD_MUL, ST_UPD_WR, ST_REP_PICK, ST_REP_DIV, ST_REP_ALPHA1,
    ST_REP_ALPHA2, ST_REP_SIZE, ST_REP_OUT, ST_REP_WAIT, ST_EMPTY
  } state_e;

  state_e state_q;
  in_item_t item_q;
  logic [SlotW-1:0] next_slot_q, rot_q;   // rot_q: slot number sitting at head
  logic [SlotW-1:0] seek_tgt;
  logic [CntW-1:0]  step_q;
  logic [6:0]       nrec_q;
  logic             any_q;
  out_item_t        rec_q;
  logic             out_valid_q, out_valid_d;
  logic             rec_load;

  // products
  logic signed [24:0] mvx_q, mvy_q, msz_q;
  logic signed [33:0] dvx_q, dvy_q;
  logic [12:0] life_q, t_q;
  logic [25:0] t2_q;
  logic [12:0] alpha_q;
  logic [15:0] size_q;
  logic        div_start, div_done;
  logic [12:0] div_quo;

  part_t head;
  assign head = ring_out[0];

  ppe_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (head.life_left),
    .den_i  (head.life_total),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  assign in_if.ready  = (state_q == ST_IDLE);
  assign out_if.valid = out_valid_q;
  assign out_if.data  = rec_q;

  // emits seek their slot, ticks start from slot 0 so records come in slot order
  assign seek_tgt = (item_q.cmd == CMD_EMIT) ? next_slot_q : '0;

  // output register load and hold
  assign rec_load = (state_q == ST_REP_OUT || state_q == ST_EMPTY)
                    && (!out_valid_q || out_if.ready);
  assign out_valid_d = rec_load || (out_valid_q && !out_if.ready);

  // combinational helpers
  logic signed [25:0] npx, npy;
  logic signed [16:0] nlife;
  logic signed [17:0] nvx, nvy;
  logic signed [17:0] nsz;
  logic signed [17:0] sdiff;
  logic signed [31:0] sprod;
  logic signed [17:0] dsize;
  logic signed [25:0] offx, offy;
  logic [38:0] a3;
  logic        last_slot;

  assign last_slot = (step_q == CntW'(POOL_SIZE - 1));
  assign nlife = head.life_left - $signed({1'b0, item_q.time_step});
  assign npx = 26'(head.pos_x) + 26'(dvx_q >>> 12);
  assign npy = 26'(head.pos_y) + 26'(dvy_q >>> 12);
  assign nvx = 18'($signed(base_vel_q[15:0])) + 18'(mvx_q >>> 8);
  assign nvy = 18'($signed(base_vel_q[31:16])) + 18'(mvy_q >>> 8);
  assign nsz = $signed({2'b0, size_begin_q}) + 18'(msz_q >>> 8);
  assign sdiff = $signed({2'b0, head.start_size}) - $signed({2'b0, head.final_size});
  assign sprod = $signed({1'b0, life_q}) * sdiff;
  assign dsize = $signed({2'b0, head.final_size}) + 18'(sprod >>> 12);
  assign offx = 26'(head.pos_x) - $signed({11'd0, size_q[15:1]});
  assign offy = 26'(head.pos_y) - $signed({11'd0, size_q[15:1]});
  assign a3 = 39'(t2_q) * 39'(13'(OneQ12) - t_q);

  assign div_start = (state_q == ST_REP_PICK) && head.active && (nrec_q < 7'(MaxRec))
                     && (head.life_total != '0);

  // shift enable and the particle re-entering at the tail
  always_comb begin
    shift    = 1'b0;
    head_new = head;
    case (state_q)
      ST_SEEK: shift = (rot_q != seek_tgt);
      ST_EMIT_WR: begin
        shift               = 1'b1;
        head_new.active     = 1'b1;
        head_new.pos_x      = item_q.emit_x;
        head_new.pos_y      = item_q.emit_y;
        head_new.vel_x      = nvx[16:0];
        head_new.vel_y      = nvy[16:0];
        head_new.life_left  = {1'b0, life_time_q};
        head_new.life_total = life_time_q;
        head_new.start_size = nsz[17] ? 16'd0 : (nsz[16] ? 16'hFFFF : nsz[15:0]);
        head_new.final_size = size_end_q;
        head_new.color      = base_color_q;
        head_new.fade       = fade_style_q;
      end
      ST_UPD_WR: begin
        shift = 1'b1;
        if (head.active) begin
          head_new.life_left = nlife;
          head_new.pos_x     = sat24(npx);
          head_new.pos_y     = sat24(npy);
          head_new.active    = (nlife > 17'sd0);
        end
      end
      ST_REP_PICK: shift = !(head.active && nrec_q < 7'(MaxRec));
      ST_REP_WAIT: shift = !out_valid_q || out_if.ready;
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      next_slot_q <= '0;
      rot_q       <= '0;
      step_q      <= '0;
      nrec_q      <= '0;
      any_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (shift) rot_q <= (rot_q == SlotW'(POOL_SIZE - 1)) ? '0 : rot_q + 1'b1;
      case (state_q)
        ST_IDLE: begin
          if (in_if.valid) begin
            step_q <= '0;
            nrec_q <= '0;
            any_q  <= 1'b0;
            state_q <= ST_SEEK;
          end
        end
        ST_SEEK: begin
          if (rot_q == seek_tgt) begin
            state_q <= (item_q.cmd == CMD_EMIT) ? ST_EMIT_MUL : ST_UPD_MUL;
          end
        end
        ST_EMIT_MUL: state_q <= ST_EMIT_WR;
        ST_EMIT_WR: begin
          next_slot_q <= (next_slot_q == SlotW'(POOL_SIZE - 1)) ? '0 : next_slot_q + 1'b1;
          state_q     <= ST_IDLE;
        end
        ST_UPD_MUL: state_q <= ST_UPD_WR;
        ST_UPD_WR: begin
          step_q <= last_slot ? '0 : step_q + 1'b1;
          state_q <= last_slot ? ST_REP_PICK : ST_UPD_MUL;
        end
        ST_REP_PICK: begin
          if (head.active && nrec_q < 7'(MaxRec)) begin
            if (head.life_total == '0) begin
              life_q  <= 13'(OneQ12);
              state_q <= ST_REP_ALPHA1;
            end else begin
              state_q <= ST_REP_DIV;
            end
          end else begin
            step_q <= step_q + 1'b1;
            if (last_slot) state_q <= any_q ? ST_IDLE : ST_EMPTY;
          end
        end
        ST_REP_DIV: if (div_done) begin
          life_q  <= div_quo;
          state_q <= ST_REP_ALPHA1;
        end
        ST_REP_ALPHA1: state_q <= ST_REP_ALPHA2;
        ST_REP_ALPHA2: state_q <= ST_REP_SIZE;
        ST_REP_SIZE:   state_q <= ST_REP_OUT;
        ST_REP_OUT: if (!out_valid_q || out_if.ready) begin
          any_q  <= 1'b1;
          nrec_q <= nrec_q + 7'd1;
          state_q <= ST_REP_WAIT;
        end
        ST_REP_WAIT: if (!out_valid_q || out_if.ready) begin
          step_q <= step_q + 1'b1;
          state_q <= last_slot ? ST_IDLE : ST_REP_PICK;
        end
        ST_EMPTY: if (!out_valid_q || out_if.ready) begin
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // last flag: set once the walk finds no further reportable slot, or at record MaxRec
  logic [POOL_SIZE-1:0] act_vec;
  logic later_any;
  always_comb begin
    for (int k = 0; k < POOL_SIZE; k++) act_vec[k] = ring_out[k].active;
    later_any = 1'b0;
    for (int k = 1; k < POOL_SIZE; k++)
      if (CntW'(k) < CntW'(POOL_SIZE) - step_q) later_any |= act_vec[k];
  end

  logic last_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) last_q <= 1'b0;
    else if (state_q == ST_REP_SIZE) last_q <= !later_any || (nrec_q == 7'(MaxRec - 1));
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_if.valid) item_q <= in_if.data;
    mvx_q <= $signed({1'b0, vel_spread_q[15:0]}) * item_q.rand_vx;
    mvy_q <= $signed({1'b0, vel_spread_q[31:16]}) * item_q.rand_vy;
    msz_q <= $signed({1'b0, size_spread_q}) * item_q.rand_size;
    dvx_q <= head.vel_x * $signed({1'b0, item_q.time_step});
    dvy_q <= head.vel_y * $signed({1'b0, item_q.time_step});
    t_q   <= 13'(OneQ12) - life_q;
    t2_q  <= 26'(t_q) * 26'(t_q);
    // t squared is registered from t, so it is ready in the cycle after t
    if (state_q == ST_REP_SIZE) alpha_q <= head.fade ? 13'(a3 >> 23) : life_q;
    if (state_q == ST_REP_ALPHA2)
      size_q <= dsize[17] ? 16'd0 : (dsize[16] ? 16'hFFFF : dsize[15:0]);
    if (state_q == ST_REP_OUT && rec_load) begin
      rec_q.slot        <= 6'(rot_q);
      rec_q.offset_x    <= sat24(offx);
      rec_q.offset_y    <= sat24(offy);
      rec_q.color_rgb   <= head.color;
      rec_q.alpha       <= alpha_q;
      rec_q.draw_size   <= size_q;
      rec_q.none_active <= 1'b0;
      rec_q.last        <= last_q;
    end
    if (state_q == ST_EMPTY && rec_load) begin
      rec_q <= '{slot: '0, offset_x: '0, offset_y: '0, color_rgb: '0, alpha: '0,
                 draw_size: '0, none_active: 1'b1, last: 1'b1};
    end
  end
endmodule

>>> sv/ppe_cell.sv
`timescale 1ns / 1ps
// one pool slot: holds a particle and passes it to its neighbor when the ring rotates
module ppe_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           shift_i,
  input  ppe_pkg::part_t part_i,
  output ppe_pkg::part_t part_o
);
  import ppe_pkg::*;

  logic  active_q;
  part_t part_q;

  // active bit is control, rest is payload
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else if (shift_i) begin
      active_q <= part_i.active;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      part_q <= part_i;
    end
  end

  always_comb begin
    part_o        = part_q;
    part_o.active = active_q;
  end
endmodule

>>> sv/ppe_div.sv
`timescale 1ns / 1ps
// restoring divider: floor(num * 4096 / den) clamped to 4096, one quotient bit per cycle
module ppe_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [16:0] num_i,
  input  logic [15:0] den_i,
  output logic        done_o,
  output logic [12:0] quo_o
);
  import ppe_pkg::*;

  localparam int unsigned NBits = 29;

  logic [28:0] num_q;
  logic [16:0] rem_q;
  logic [15:0] den_q;
  logic [4:0]  cnt_q;
  logic        busy_q, done_q;
  logic [17:0] trial;
  logic [16:0] rem_sh;

  assign rem_sh = {rem_q[15:0], num_q[28]};
  assign trial  = {1'b0, rem_sh} - {2'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'(NBits - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= {num_i, 12'd0};
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      if (!trial[17]) begin
        rem_q <= trial[16:0];
        num_q <= {num_q[27:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        num_q <= {num_q[27:0], 1'b0};
      end
    end
  end

  // quotient collects in the low bits of the shifted numerator, clamp to one
  assign done_o = done_q;
  assign quo_o  = (num_q[28:12] != '0 || num_q[11:0] > 12'(OneQ12 - 1)) ?
                  13'(OneQ12) : {1'b0, num_q[11:0]};
endmodule
